// ===== hw/rtl/bstf_pkg.sv =====
// Shared types and constants for the BMP grayscale / threshold byte filter.
// No dependencies; imported by bstf_core, bstf_fifo and the top level.
`timescale 1ns / 1ps

package bstf_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd128;

    // Most result bytes one input byte can cause (a red byte completes a pixel)
    localparam int MAX_PUSH = 3;

    // Default depth of the result queue
    localparam int FIFO_DEPTH = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Results of one processed byte, handed to the result queue
    typedef struct packed {
        logic [1:0]                   cnt;
        out_item_t [MAX_PUSH-1:0]     item;
    } push_t;

endpackage

// ===== hw/rtl/bstf_core.sv =====
// Header capture, pixel grouping and grayscale / threshold mapping.
// Depends on bstf_pkg; feeds up to three result bytes a cycle into bstf_fifo.
`timescale 1ns / 1ps

module bstf_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  bstf_pkg::in_item_t            src_data,
    input  logic                          cfg_we,
    input  logic [bstf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bstf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                          room,
    output bstf_pkg::push_t               push
);
    import bstf_pkg::*;

    localparam logic [31:0] OFFSET_FIRST = 32'd10;
    localparam logic [31:0] OFFSET_LAST  = 32'd13;
    localparam logic [31:0] WIDTH_FIRST  = 32'd18;
    localparam logic [31:0] HEIGHT_LAST  = 32'd25;
    localparam logic [31:0] HEIGHT_FIRST = 32'd22;
    localparam logic [31:0] HEADER_END   = 32'd26;
    localparam logic [7:0]  PIXEL_WHITE  = 8'hff;
    localparam logic [7:0]  PIXEL_BLACK  = 8'h00;
    // floor(s * 683 / 2048) == floor(s / 3) for every s below 2048
    localparam logic [9:0]  RECIP_THREE  = 10'd683;

    // Overwrite one byte lane of a little-endian header word
    function automatic logic [31:0] put_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

    // Configuration registers
    logic       gray_mode_reg;
    logic [7:0] threshold_reg;

    // Input register
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // Stream state
    logic [31:0] byte_pos_reg,   byte_pos_next;
    logic [31:0] offset_reg,     offset_next;
    logic [31:0] width_reg,      width_next;
    logic [31:0] height_reg,     height_next;
    logic [7:0]  held0_reg,      held0_next;
    logic [7:0]  held1_reg,      held1_next;
    logic [1:0]  phase_reg,      phase_next;
    logic [31:0] col_reg,        col_next;
    logic [31:0] row_reg,        row_next;
    logic [1:0]  pad_reg,        pad_next;
    logic        done_reg,       done_next;

    logic        accept;
    logic        go;
    logic        hdr_ok;
    logic        in_image;
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  avg;
    logic [7:0]  pix;
    logic [7:0]  b;
    logic        last;

    assign src_stall = s1_valid_reg && !room;
    assign accept    = src_valid && !src_stall;
    assign go        = s1_valid_reg && room;
    assign b         = s1_item_reg.in_byte;
    assign last      = s1_item_reg.in_last;

    // Average of the held blue and green bytes and the current red byte
    assign sum  = {2'b00, held0_reg} + {2'b00, held1_reg} + {2'b00, b};
    assign prod = 20'(sum) * 20'(RECIP_THREE);
    assign avg  = prod[18:11];
    assign pix  = gray_mode_reg ? avg : ((avg >= threshold_reg) ? PIXEL_WHITE : PIXEL_BLACK);

    // Per-byte state update and result generation
    always_comb
    begin
        byte_pos_next = (byte_pos_reg != 32'hffff_ffff) ? byte_pos_reg + 32'd1 : byte_pos_reg;
        offset_next   = offset_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        phase_next    = phase_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        done_next     = done_reg;

        push.cnt = 2'd1;
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            push.item[i] = '{out_byte: b, out_last: 1'b0};
        end

        // header words; every field starts at a position that is 2 mod 4
        if (byte_pos_reg >= OFFSET_FIRST && byte_pos_reg <= OFFSET_LAST)
            offset_next = put_lane(offset_reg, byte_pos_reg[1:0] - 2'd2, b);
        else if (byte_pos_reg >= WIDTH_FIRST && byte_pos_reg < HEIGHT_FIRST)
            width_next = put_lane(width_reg, byte_pos_reg[1:0] - 2'd2, b);
        else if (byte_pos_reg >= HEIGHT_FIRST && byte_pos_reg <= HEIGHT_LAST)
            height_next = put_lane(height_reg, byte_pos_reg[1:0] - 2'd2, b);

        hdr_ok = offset_next >= HEADER_END &&
                 width_next != 32'd0 && !width_next[31] &&
                 height_next != 32'd0 && !height_next[31];
        in_image = hdr_ok && !done_reg && byte_pos_reg >= HEADER_END &&
                   byte_pos_reg >= offset_next;

        if (!in_image)
        begin
            push.cnt = 2'd1;
        end
        else if (pad_reg != 2'd0)
        begin
            // row padding passes through
            push.cnt = 2'd1;
            pad_next = pad_reg - 2'd1;
            if (pad_reg == 2'd1)
            begin
                row_next = row_reg + 32'd1;
                if (row_next == height_next)
                    done_next = 1'b1;
            end
        end
        else if (phase_reg != 2'd2)
        begin
            // blue or green: hold it, unless the file ends here
            if (phase_reg[0])
                held1_next = b;
            else
                held0_next = b;
            phase_next = phase_reg + 2'd1;
            push.cnt   = 2'd0;
            if (last)
            begin
                if (phase_reg == 2'd0)
                begin
                    push.cnt = 2'd1;
                end
                else
                begin
                    push.cnt = 2'd2;
                    push.item[0].out_byte = held0_reg;
                end
            end
        end
        else
        begin
            // red completes the pixel
            push.cnt = 2'd3;
            for (int i = 0; i < MAX_PUSH; i++)
            begin
                push.item[i].out_byte = pix;
            end
            phase_next = 2'd0;
            col_next   = col_reg + 32'd1;
            if (col_next == width_next)
            begin
                col_next = 32'd0;
                pad_next = width_next[1:0];
                if (width_next[1:0] == 2'd0)
                begin
                    row_next = row_reg + 32'd1;
                    if (row_next == height_next)
                        done_next = 1'b1;
                end
            end
        end

        // end of file: flag the final result and return to the reset state
        if (last)
        begin
            case (push.cnt)
                2'd1:    push.item[0].out_last = 1'b1;
                2'd2:    push.item[1].out_last = 1'b1;
                2'd3:    push.item[2].out_last = 1'b1;
                default: ;
            endcase
            byte_pos_next = '0;
            offset_next   = '0;
            width_next    = '0;
            height_next   = '0;
            held0_next    = '0;
            held1_next    = '0;
            phase_next    = '0;
            col_next      = '0;
            row_next      = '0;
            pad_next      = '0;
            done_next     = 1'b0;
        end

        if (!go)
            push.cnt = 2'd0;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAY_MODE: gray_mode_reg <= cfg_data[0];
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= src_data;
    end

    // Stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            offset_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            held0_reg    <= '0;
            held1_reg    <= '0;
            phase_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            pad_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else if (go)
        begin
            byte_pos_reg <= byte_pos_next;
            offset_reg   <= offset_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pad_reg      <= pad_next;
            done_reg     <= done_next;
        end
    end

`ifndef SYNTH
    // a pixel never has more than two held colour bytes
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("colour phase out of range");

    // padding only starts on a pixel boundary
    a_pad_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != 2'd0 |-> phase_reg == 2'd0)
        else $error("padding pending mid-pixel");

    // a byte held in the input register is not lost while it waits
    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !room) |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stalled input byte changed");
`endif

endmodule

// ===== hw/rtl/bstf_fifo.sv =====
// Result queue: takes up to three result bytes a cycle, delivers one.
// Depends on bstf_pkg for the item and push types.
`timescale 1ns / 1ps

module bstf_fifo #(
    parameter int DEPTH = bstf_pkg::FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bstf_pkg::push_t      push,
    output logic                 room,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output bstf_pkg::out_item_t  dst_data
);
    import bstf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - MAX_PUSH);

    out_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] wr_idx [MAX_PUSH+1];
    logic [SUM_W-1:0] idx_sum;
    logic             pop;

    assign room      = count_reg <= ROOM_MAX;
    assign dst_valid = count_reg != '0;
    assign dst_data  = mem_reg[rd_ptr_reg];
    assign pop       = dst_valid && !dst_stall;

    // Write slots for the pushed bytes, wrapping at the depth
    always_comb
    begin
        for (int i = 0; i <= MAX_PUSH; i++)
        begin
            idx_sum = {2'b00, wr_ptr_reg} + SUM_W'(i);
            if (idx_sum >= SUM_W'(DEPTH))
                idx_sum = idx_sum - SUM_W'(DEPTH);
            wr_idx[i] = idx_sum[PTR_W-1:0];
        end
        wr_ptr_next = wr_idx[0];
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_idx[1];
            2'd2:    wr_ptr_next = wr_idx[2];
            2'd3:    wr_ptr_next = wr_idx[3];
            default: wr_ptr_next = wr_idx[0];
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (2'(i) < push.cnt)
                mem_reg[wr_idx[i]] <= push.item[i];
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("push without room");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.cnt == 2'd0) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not reduce fill count");
`endif

endmodule

// ===== hw/rtl/bmp_stream_gray_threshold_filter.sv =====
// Top level of the BMP grayscale / threshold byte-stream filter.
// Depends on bstf_pkg, bstf_core and bstf_fifo.
//
//  channel  direction  handshake             payload
//  src      in         src_valid/src_stall   src_data (in_byte, in_last)
//  dst      out        dst_valid/dst_stall   dst_data (out_byte, out_last)
//  cfg      in         cfg_we                cfg_index, cfg_data
//
// One byte is accepted per cycle while src is not stalled; each result byte
// goes through the input register, then the result queue, to dst. A red
// byte releases three results at once; dst drains one per unstalled cycle.
// src stalls only while the input register is full and the queue has fewer
// than three free slots. Reset clears all stream state and the queue and
// sets gray_mode to 0 and threshold to 128.
`timescale 1ns / 1ps

module bmp_stream_gray_threshold_filter #(
    parameter int FIFO_DEPTH = bstf_pkg::FIFO_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             src_valid,
    output logic                             src_stall,
    input  bstf_pkg::in_item_t               src_data,
    output logic                             dst_valid,
    input  logic                             dst_stall,
    output bstf_pkg::out_item_t              dst_data,
    input  logic                             cfg_we,
    input  logic [bstf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bstf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bstf_pkg::*;

    push_t push;
    logic  room;

    // Per-byte filtering
    bstf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push)
    );

    // Result queue
    bstf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule
